>>> rtl/bnc_pkg.sv
// ----------------------------------------------------------------------------
// bnc_pkg
// Shared types and constants of the bracket nesting checker.
// ----------------------------------------------------------------------------
package bnc_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned PosW            = 16;

  // item action codes
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_EOL  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_UNCLOSED = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;  // (
  localparam logic [7:0] CH_RPAREN = 8'h29;  // )
  localparam logic [7:0] CH_STAR   = 8'h2A;  // *
  localparam logic [7:0] CH_LBRACK = 8'h5B;  // [
  localparam logic [7:0] CH_RBRACK = 8'h5D;  // ]
  localparam logic [7:0] CH_LBRACE = 8'h7B;  // {
  localparam logic [7:0] CH_RBRACE = 8'h7D;  // }
  localparam logic [7:0] CH_LANGLE = 8'h3C;  // <
  localparam logic [7:0] CH_RANGLE = 8'h3E;  // >

  typedef enum logic [2:0] {
    KIND_ROUND   = 3'd1,
    KIND_SQUARE  = 3'd2,
    KIND_CURLY   = 3'd3,
    KIND_ANGLE   = 3'd4,
    KIND_COMMENT = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_PAREN = 2'd1,
    HELD_STAR  = 2'd2
  } held_t;

  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [PosW-1:0] error_position;
  } out_item_t;

  // one physical stack slot; may carry an extra round open directly below it
  typedef struct packed {
    logic            extra;
    logic [PosW-1:0] extra_pos;
    kind_t           kind;
    logic [PosW-1:0] pos;
  } stack_entry_t;

endpackage

>>> rtl/bnc_ram.sv
// ----------------------------------------------------------------------------
// bnc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bnc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/bracket_nesting_checker_core.sv
// ----------------------------------------------------------------------------
// bracket_nesting_checker_core
// Streaming bracket nesting checker, one character item per cycle.
// ----------------------------------------------------------------------------
// Each item is a character of a line or an end-of-line marker. Items go into
// an input register and are resolved there against the stack top, so one
// item is taken every clock; an end-of-line item moves its result into the
// output register, which drives out_valid. The only stall is an end-of-line
// item whose result register is still occupied by an untaken result. The
// stack keeps its top slot in flip-flops and the slots below in a RAM whose
// read port always prefetches the slot under the top, so pushes and
// pops do not wait for the RAM. A round open that is followed by another open is
// folded into the new slot, which keeps the RAM to one write per cycle. No
// clearing pass is needed after reset; the RAM is only read below the fill
// level.
module bracket_nesting_checker_core #(
  parameter int unsigned STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bnc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output bnc_pkg::out_item_t out_item
);

  import bnc_pkg::*;

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned EntW  = $bits(stack_entry_t);

  // input stage
  logic      s_valid_r;
  in_item_t  s_item_r;
  logic      s_go;
  logic      s_eol;
  logic      out_free;

  // result stage
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t res;

  // line state
  logic [CntW-1:0] p_r, p_nxt;        // physical slots incl. top
  logic [CntW-1:0] n_r, n_nxt;        // logical open count
  stack_entry_t    top_r, top_nxt;
  held_t           held_r, held_nxt;
  logic [PosW-1:0] held_pos_r, held_pos_nxt;
  logic [PosW-1:0] cc_r, cc_nxt;
  logic            err_r, err_nxt;
  logic [1:0]      err_code_r, err_code_nxt;
  logic [PosW-1:0] err_pos_r, err_pos_nxt;

  // stack ram and read bypass
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [AddrW-1:0] ram_raddr;
  stack_entry_t     ram_rdata;
  logic             byp_r, byp_nxt;
  stack_entry_t     byp_data_r;
  stack_entry_t     second;

  // per-item decode
  logic [7:0]      c;
  logic [PosW-1:0] pos;
  logic            n_full, n_one_short, n_empty;
  logic            is_open, is_close;
  kind_t           c_kind;
  logic            a_push;
  logic            push_one, push_two, pop_one;
  stack_entry_t    push_entry;
  logic            e_set;
  logic [1:0]      e_code;
  logic [PosW-1:0] e_pos;

  // handshakes
  assign s_eol    = (s_item_r.action == ACT_EOL);
  assign out_free = !out_valid_r || out_ready;
  assign s_go     = s_valid_r && (!s_eol || out_free);
  assign in_ready = !s_valid_r || s_go;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // slot under the top: freshly written slot comes from the bypass
  assign second = byp_r ? byp_data_r : ram_rdata;

  // character decode
  always_comb begin
    is_open  = 1'b0;
    is_close = 1'b0;
    c_kind   = KIND_ROUND;
    unique case (c)
      CH_LBRACK: begin is_open  = 1'b1; c_kind = KIND_SQUARE; end
      CH_LBRACE: begin is_open  = 1'b1; c_kind = KIND_CURLY;  end
      CH_LANGLE: begin is_open  = 1'b1; c_kind = KIND_ANGLE;  end
      CH_RPAREN: begin is_close = 1'b1; c_kind = KIND_ROUND;  end
      CH_RBRACK: begin is_close = 1'b1; c_kind = KIND_SQUARE; end
      CH_RBRACE: begin is_close = 1'b1; c_kind = KIND_CURLY;  end
      CH_RANGLE: begin is_close = 1'b1; c_kind = KIND_ANGLE;  end
      default: begin end
    endcase
  end

  assign c           = s_item_r.char_code;
  assign pos         = (cc_r == '1) ? cc_r : PosW'(cc_r + 1'b1);  // saturating
  assign n_full      = (n_r == CntW'(STACK_DEPTH));
  assign n_one_short = (n_r == CntW'(STACK_DEPTH - 1));
  assign n_empty     = (n_r == '0);

  // resolve one item against held char and stack top
  always_comb begin
    a_push       = 1'b0;
    push_one     = 1'b0;
    push_two     = 1'b0;
    pop_one      = 1'b0;
    push_entry   = '{extra: 1'b0, extra_pos: '0, kind: KIND_ROUND, pos: held_pos_r};
    e_set        = 1'b0;
    e_code       = ST_OK;
    e_pos        = '0;
    held_nxt     = held_r;
    held_pos_nxt = held_pos_r;

    if (!err_r) begin
      if (s_eol) begin
        // held paren counts as an open, and would be the new top
        if (held_r == HELD_PAREN) begin
          e_set  = 1'b1;
          e_code = n_full ? ST_OVERFLOW : ST_UNCLOSED;
          e_pos  = held_pos_r;
        end else if (!n_empty) begin
          e_set  = 1'b1;
          e_code = ST_UNCLOSED;
          e_pos  = top_r.pos;
        end
      end else begin
        held_nxt = HELD_NONE;
        if (held_r == HELD_PAREN && c == CH_STAR) begin
          // comment open
          if (n_full) begin
            e_set  = 1'b1;
            e_code = ST_OVERFLOW;
            e_pos  = held_pos_r;
          end else begin
            push_one        = 1'b1;
            push_entry.kind = KIND_COMMENT;
          end
        end else if (held_r == HELD_STAR && c == CH_RPAREN) begin
          // comment close
          if (n_empty || top_r.kind != KIND_COMMENT) begin
            e_set  = 1'b1;
            e_code = ST_MISMATCH;
            e_pos  = held_pos_r;
          end else begin
            pop_one = 1'b1;
          end
        end else if (held_r == HELD_PAREN && n_full) begin
          // held paren does not fit, the new char is dropped
          e_set  = 1'b1;
          e_code = ST_OVERFLOW;
          e_pos  = held_pos_r;
        end else begin
          a_push = (held_r == HELD_PAREN);
          if (c == CH_LPAREN || c == CH_STAR) begin
            held_nxt     = (c == CH_LPAREN) ? HELD_PAREN : HELD_STAR;
            held_pos_nxt = pos;
            push_one     = a_push;
          end else if (is_open) begin
            if (a_push) begin
              if (n_one_short) begin
                e_set  = 1'b1;
                e_code = ST_OVERFLOW;
                e_pos  = pos;
              end else begin
                // round open folded under the new slot
                push_two   = 1'b1;
                push_entry = '{extra: 1'b1, extra_pos: held_pos_r, kind: c_kind, pos: pos};
              end
            end else if (n_full) begin
              e_set  = 1'b1;
              e_code = ST_OVERFLOW;
              e_pos  = pos;
            end else begin
              push_one   = 1'b1;
              push_entry = '{extra: 1'b0, extra_pos: '0, kind: c_kind, pos: pos};
            end
          end else if (is_close) begin
            if (a_push) begin
              // close right after the paren: ')' cancels it
              if (c_kind != KIND_ROUND) begin
                e_set  = 1'b1;
                e_code = ST_MISMATCH;
                e_pos  = pos;
              end
            end else if (n_empty || top_r.kind != c_kind) begin
              e_set  = 1'b1;
              e_code = ST_MISMATCH;
              e_pos  = pos;
            end else begin
              pop_one = 1'b1;
            end
          end else begin
            push_one = a_push;
          end
        end
      end
    end
  end

  // next line state
  always_comb begin
    p_nxt        = p_r;
    n_nxt        = n_r;
    top_nxt      = top_r;
    cc_nxt       = cc_r;
    err_nxt      = err_r;
    err_code_nxt = err_code_r;
    err_pos_nxt  = err_pos_r;

    res.status         = err_r ? err_code_r : (e_set ? e_code : ST_OK);
    res.error_position = err_r ? err_pos_r  : (e_set ? e_pos  : '0);

    if (s_go) begin
      if (s_eol) begin
        p_nxt        = '0;
        n_nxt        = '0;
        cc_nxt       = '0;
        err_nxt      = 1'b0;
        err_code_nxt = ST_OK;
        err_pos_nxt  = '0;
      end else begin
        cc_nxt = pos;
        if (e_set) begin
          err_nxt      = 1'b1;
          err_code_nxt = e_code;
          err_pos_nxt  = e_pos;
        end
        if (push_one || push_two) begin
          top_nxt = push_entry;
          p_nxt   = p_r + 1'b1;
          n_nxt   = push_two ? CntW'(n_r + 2'd2) : CntW'(n_r + 1'b1);
        end else if (pop_one) begin
          n_nxt = n_r - 1'b1;
          if (top_r.extra) begin
            // unfold the round open kept in this slot
            top_nxt = '{extra: 1'b0, extra_pos: '0, kind: KIND_ROUND, pos: top_r.extra_pos};
          end else begin
            p_nxt   = p_r - 1'b1;
            top_nxt = second;
          end
        end
      end
    end
  end

  // old top spills into the ram on a push
  assign ram_we    = s_go && !s_eol && (push_one || push_two) && (p_r != '0);
  assign ram_waddr = AddrW'(p_r - 1'b1);
  assign ram_raddr = AddrW'(p_nxt - CntW'(2));
  assign byp_nxt   = ram_we && (ram_waddr == ram_raddr);

  bnc_ram #(
    .Width (EntW),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (top_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      p_r         <= '0;
      n_r         <= '0;
      held_r      <= HELD_NONE;
      held_pos_r  <= '0;
      cc_r        <= '0;
      err_r       <= 1'b0;
      err_code_r  <= ST_OK;
      err_pos_r   <= '0;
      byp_r       <= 1'b0;
    end else begin
      if (in_ready) begin
        s_valid_r <= in_valid;
      end
      if (s_go && s_eol) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      p_r        <= p_nxt;
      n_r        <= n_nxt;
      cc_r       <= cc_nxt;
      err_r      <= err_nxt;
      err_code_r <= err_code_nxt;
      err_pos_r  <= err_pos_nxt;
      byp_r      <= byp_nxt;
      if (s_go) begin
        held_r     <= s_eol ? HELD_NONE : held_nxt;
        held_pos_r <= s_eol ? '0 : held_pos_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_item_r <= in_item;
    end
    if (s_go && s_eol) begin
      out_item_r <= res;
    end
    top_r      <= top_nxt;
    byp_data_r <= top_r;
  end

  // every slot holds one or two opens
  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r >= p_r) && ((CntW+1)'(n_r) <= ((CntW+1)'(p_r) << 1)))
    else $error("open count out of line with slot count");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CntW'(STACK_DEPTH))
    else $error("open count beyond stack depth");

  // bypass only after a push onto a nonempty stack
  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    byp_r |-> (p_r >= CntW'(2)))
    else $error("read bypass with fewer than two slots");

  a_eol_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s_go && s_eol) |=> (p_r == '0 && n_r == '0 && !err_r && cc_r == '0 &&
                         held_r == HELD_NONE))
    else $error("line state not cleared after end of line");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (err_code_r != ST_OK))
    else $error("error flagged with balanced status");

  a_eol_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid_r && s_eol && out_valid_r && !out_ready) |-> !in_ready)
    else $error("item taken while end of line result is blocked");

endmodule
